/* src/bad_block_set_table_core_defines.svh */
// Assertion macros for the bad block set table core.
// Used by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef BAD_BLOCK_SET_TABLE_CORE_DEFINES_SVH
`define BAD_BLOCK_SET_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define BBST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define BBST_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define BBST_ASSERT(lbl, prop, msg)
`define BBST_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* src/bbst_pkg.sv */
// Shared types and constants for the bad block set table core.
// No dependencies.
`timescale 1ns / 1ps

package bbst_pkg;

  localparam int unsigned BlkW = 32;
  localparam int unsigned OpW  = 3;

  // operation codes
  localparam logic [OpW-1:0] OP_ADD    = 3'd0;
  localparam logic [OpW-1:0] OP_TEST   = 3'd1;
  localparam logic [OpW-1:0] OP_REWIND = 3'd2;
  localparam logic [OpW-1:0] OP_NEXT   = 3'd3;
  localparam logic [OpW-1:0] OP_CLEAR  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_NEXT = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  typedef struct packed {
    logic            status;
    logic            present;
    logic [BlkW-1:0] read_block;
    logic            read_valid;
  } res_t;

endpackage

/* src/bbst_req_if.sv */
// Request channel interface: operation and block number with valid/ready.
// Depends on bbst_pkg.
`timescale 1ns / 1ps

interface bbst_req_if
  import bbst_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  operation;
  logic [BlkW-1:0] block_number;

  modport source (output valid, output operation, output block_number, input ready);
  modport sink   (input valid, input operation, input block_number, output ready);
endinterface

/* src/bbst_rsp_if.sv */
// Response channel interface: status, present, read block and read valid flag.
// Depends on bbst_pkg.
`timescale 1ns / 1ps

interface bbst_rsp_if
  import bbst_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            status;
  logic            present;
  logic [BlkW-1:0] read_block;
  logic            read_valid;

  modport source (output valid, output status, output present, output read_block,
                  output read_valid, input ready);
  modport sink   (input valid, input status, input present, input read_block,
                  input read_valid, output ready);
endinterface

/* src/bbst_mem.sv */
// Entry store: single write port, single read port with registered read data.
// Depends on bbst_pkg for the entry width.
`timescale 1ns / 1ps

module bbst_mem
  import bbst_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [BlkW-1:0] wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [BlkW-1:0] rdata_o
);

  logic [BlkW-1:0] mem_q [DEPTH];
  logic [BlkW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bbst_seq.sv */
// Sequencer: walks the entry store one entry per cycle through a shared
// equality comparator and index compare; owns count and read pointer.
// Depends on bbst_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bad_block_set_table_core_defines.svh"

module bbst_seq
  import bbst_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  logic [OpW-1:0]  req_op_i,
  input  logic [BlkW-1:0] req_blk_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output res_t            res_o,
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output logic [BlkW-1:0] mem_wdata_o,
  output logic            mem_re_o,
  output logic [AW-1:0]   mem_raddr_o,
  input  logic [BlkW-1:0] mem_rdata_i
);

  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  state_e          state_q, state_d;
  logic [OpW-1:0]  op_q, op_d;
  logic [BlkW-1:0] blk_q, blk_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            pend_q, pend_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   rp_q, rp_d;
  res_t            res_q, res_d;

  logic [CW-1:0]   cmp_idx;
  logic            lt;
  logic            hit;

  // shared compare unit: index against fill count, entry against key
  assign cmp_idx = (state_q == ST_IDLE) ? rp_q : idx_q;
  assign lt      = (cmp_idx < cnt_q);
  assign hit     = pend_q && (mem_rdata_i == blk_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    blk_d       = blk_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    cnt_d       = cnt_q;
    rp_d        = rp_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d    = req_op_i;
          blk_d   = req_blk_i;
          idx_d   = '0;
          res_d   = '0;
          state_d = ST_RESP;
          unique case (req_op_i)
            OP_ADD, OP_TEST: begin
              state_d = ST_SCAN;
            end
            OP_REWIND: begin
              rp_d = '0;
            end
            OP_NEXT: begin
              if (lt) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = rp_q[AW-1:0];
                state_d     = ST_NEXT;
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
              rp_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_d.present = 1'b1;
          state_d       = ST_RESP;
        end else if (!pend_q && !lt) begin
          // scan exhausted without a match
          if (op_q == OP_ADD) begin
            if (cnt_q >= CapC) begin
              res_d.status = 1'b1;
            end else begin
              mem_we_o = 1'b1;
              cnt_d    = cnt_q + CW'(1);
            end
          end
          state_d = ST_RESP;
        end else if (lt) begin
          mem_re_o = 1'b1;
          idx_d    = idx_q + CW'(1);
          pend_d   = 1'b1;
        end
      end
      ST_NEXT: begin
        res_d.read_block = mem_rdata_i;
        res_d.read_valid = 1'b1;
        rp_d             = rp_q + CW'(1);
        state_d          = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      rp_q    <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      rp_q    <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    blk_q <= blk_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;
  assign mem_waddr_o = cnt_q[AW-1:0];
  assign mem_wdata_o = blk_q;

  `BBST_ASSERT_NEVER(a_cnt_max, cnt_q > CapC, "entry count above capacity")
  `BBST_ASSERT_NEVER(a_rp_le_cnt, rp_q > cnt_q, "read pointer past entry count")
  `BBST_ASSERT_NEVER(a_we_full, mem_we_o && (cnt_q >= CapC), "write into full table")
  `BBST_ASSERT(a_cnt_step, (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == '0)), "entry count moved by more than one")
  `BBST_ASSERT_NEVER(a_res_excl, res_valid_o && res_o.status && res_o.present, "full and present together")

endmodule

/* src/bad_block_set_table_core.sv */
// Top level of the bad block set table: sequencer, entry store and output register.
// Depends on bbst_pkg, bbst_req_if, bbst_rsp_if, bbst_mem and bbst_seq.
//
//   channel   dir   modport   payload
//   req_i     in    sink      operation[2:0], block_number[31:0]
//   rsp_o     out   source    status, present, read_block[31:0], read_valid
//
// Add and test walk the n stored entries one per cycle through the store's read
// port, stopping at the first hit or after the last entry. Read next reads the
// entry at the read pointer if that is below the count; other cases respond directly.
// Reset clears state, entry count, read pointer and output valid only.
// The output register holds a finished result while the next request is taken;
// a result waits in the sequencer, stalling input, only while that register is full.
`timescale 1ns / 1ps

module bad_block_set_table_core
  import bbst_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbst_req_if.sink   req_i,
  bbst_rsp_if.source rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic            res_valid;
  logic            res_ready;
  res_t            res;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [BlkW-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [BlkW-1:0] mem_rdata;

  logic            out_valid_q, out_valid_d;
  res_t            out_q;

  bbst_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_op_i    (req_i.operation),
    .req_blk_i   (req_i.block_number),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bbst_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register is free when empty or drained this cycle
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, loaded once per result transaction
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.present    = out_q.present;
  assign rsp_o.read_block = out_q.read_block;
  assign rsp_o.read_valid = out_q.read_valid;

endmodule
